[rtl/core/cfss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_pkg: shared types and constants for the clock field set sequencer
// Command codes, edit positions, field limits and the edit state record.
// ----------------------------------------------------------------------------
package cfss_pkg;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StepW   = 7;

  localparam logic [HourW-1:0]   HOUR_MAX   = HourW'(23);
  localparam logic [MinuteW-1:0] MINUTE_MAX = MinuteW'(59);
  localparam logic [YearW-1:0]   YEAR_MAX   = YearW'(99);
  localparam logic [MonthW-1:0]  MONTH_MIN  = MonthW'(1);
  localparam logic [MonthW-1:0]  MONTH_MAX  = MonthW'(12);
  localparam logic [DayW-1:0]    DAY_MIN    = DayW'(1);
  localparam logic [DayW-1:0]    DAY_MAX    = DayW'(31);

  localparam logic [CmdW-1:0] CMD_LOAD = 3'd0;
  localparam logic [CmdW-1:0] CMD_NEXT = 3'd1;
  localparam logic [CmdW-1:0] CMD_PREV = 3'd2;
  localparam logic [CmdW-1:0] CMD_UP   = 3'd3;
  localparam logic [CmdW-1:0] CMD_DOWN = 3'd4;

  localparam logic [PosW-1:0] POS_HOUR   = 3'd0;
  localparam logic [PosW-1:0] POS_MINUTE = 3'd1;
  localparam logic [PosW-1:0] POS_YEAR   = 3'd2;
  localparam logic [PosW-1:0] POS_MONTH  = 3'd3;
  localparam logic [PosW-1:0] POS_DAY    = 3'd4;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
  } time_fields_t;

  typedef struct packed {
    time_fields_t    fields;
    logic [PosW-1:0] pos;
    logic            done;
  } edit_state_t;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    time_fields_t    load;
  } edit_item_t;

  // One wrapping step of a field within lo..hi; values outside go to hi on a decrement and to lo on an increment.
  function automatic logic [StepW-1:0] wrap_step(input logic [StepW-1:0] v,
                                                 input logic [StepW-1:0] lo,
                                                 input logic [StepW-1:0] hi,
                                                 input logic             dec);
    logic [StepW-1:0] res;
    if (dec) begin
      if (v <= lo || v > hi) res = hi;
      else res = v - StepW'(1);
    end else begin
      if (v >= hi || v < lo) res = lo;
      else res = v + StepW'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/core/cfss_next.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfss_next: next edit state
// Applies one command (load, next, previous, up, down) to the edit state.
// ----------------------------------------------------------------------------
module cfss_next (
  input  cfss_pkg::edit_state_t cur,
  input  cfss_pkg::edit_item_t  item,
  output cfss_pkg::edit_state_t nxt
);
  import cfss_pkg::*;

  time_fields_t clamped;
  logic         dec;

  always_comb begin
    clamped = item.load;
    if (item.load.hour > HOUR_MAX) clamped.hour = HOUR_MAX;
    if (item.load.minute > MINUTE_MAX) clamped.minute = MINUTE_MAX;
    if (item.load.year > YEAR_MAX) clamped.year = YEAR_MAX;
    if (item.load.month < MONTH_MIN) clamped.month = MONTH_MIN;
    else if (item.load.month > MONTH_MAX) clamped.month = MONTH_MAX;
    if (item.load.day < DAY_MIN) clamped.day = DAY_MIN;
  end

  assign dec = (item.cmd == CMD_UP);

  always_comb begin
    nxt = cur;
    if (item.cmd == CMD_LOAD) begin
      nxt.fields = clamped;
      nxt.pos    = POS_HOUR;
      nxt.done   = 1'b0;
    end else if (!cur.done) begin
      unique case (item.cmd)
        CMD_NEXT: begin
          if (cur.pos >= POS_DAY) begin
            nxt.pos  = POS_DAY;
            nxt.done = 1'b1;
          end else begin
            nxt.pos = cur.pos + PosW'(1);
          end
        end
        CMD_PREV: begin
          if (cur.pos != POS_HOUR) nxt.pos = cur.pos - PosW'(1);
        end
        CMD_UP, CMD_DOWN: begin
          unique case (cur.pos)
            POS_HOUR: nxt.fields.hour = HourW'(wrap_step(StepW'(cur.fields.hour),
                StepW'(0), StepW'(HOUR_MAX), dec));
            POS_MINUTE: nxt.fields.minute = MinuteW'(wrap_step(
                StepW'(cur.fields.minute), StepW'(0), StepW'(MINUTE_MAX), dec));
            POS_YEAR: nxt.fields.year = YearW'(wrap_step(StepW'(cur.fields.year),
                StepW'(0), StepW'(YEAR_MAX), dec));
            POS_MONTH: nxt.fields.month = MonthW'(wrap_step(StepW'(cur.fields.month),
                StepW'(MONTH_MIN), StepW'(MONTH_MAX), dec));
            POS_DAY: nxt.fields.day = DayW'(wrap_step(StepW'(cur.fields.day),
                StepW'(DAY_MIN), StepW'(DAY_MAX), dec));
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/clock_field_set_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, next-state logic, then the edit state register, which also
// serves as the result register.
// Throughput: one item per cycle unless the output stalls (out_tready low).
// Reset (synchronous, rst_n low): both stages empty, fields 00:00 year 0, month 1,
// day 1, position hour, done clear.
// ----------------------------------------------------------------------------
// clock_field_set_sequencer: button-driven time-setting sequencer
// Input register, next-state update and registered edit state on the output.
// ----------------------------------------------------------------------------
module clock_field_set_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: load_hour[4:0], load_minute[10:5], load_year[17:11],
  //        load_month[21:18], load_day[26:22], zero[31:27]
  input  wire logic [31:0] in_tdata,
  // tuser: command[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: hour_out[4:0], minute_out[10:5], year_out[17:11], month_out[21:18],
  //        day_out[26:22], edit_position[29:27], done_res[30], zero[31]
  output logic [31:0]      out_tdata
);
  import cfss_pkg::*;

  edit_item_t  item_r, item_nxt;
  logic        item_valid_r;
  edit_state_t state_r, state_nxt;
  logic        out_valid_r;
  logic        advance;

  // The item moves on when the result slot is empty or being drained.
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  always_comb begin
    item_nxt.cmd         = in_tuser;
    item_nxt.load.hour   = in_tdata[4:0];
    item_nxt.load.minute = in_tdata[10:5];
    item_nxt.load.year   = in_tdata[17:11];
    item_nxt.load.month  = in_tdata[21:18];
    item_nxt.load.day    = in_tdata[26:22];
  end

  cfss_next u_next (
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r          <= 1'b0;
      state_r.fields.hour   <= '0;
      state_r.fields.minute <= '0;
      state_r.fields.year   <= '0;
      state_r.fields.month  <= MONTH_MIN;
      state_r.fields.day    <= DAY_MIN;
      state_r.pos           <= POS_HOUR;
      state_r.done          <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, state_r.done, state_r.pos, state_r.fields.day,
                       state_r.fields.month, state_r.fields.year,
                       state_r.fields.minute, state_r.fields.hour};

endmodule
`default_nettype wire

[dv/tb_clock_field_set_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_field_set_sequencer: self-checking bench for the time-set sequencer
// Button items are queued up front and played into the input stream with
// random gaps. An in-bench predictor tracks the edit fields, position and
// done flag. Every result on the output stream is compared field by field
// with the oldest predicted state, under random receiver stalls.
// ----------------------------------------------------------------------------
module tb_clock_field_set_sequencer;
  import cfss_pkg::*;

  localparam int unsigned ITEMS     = 1950;
  localparam int unsigned CALM_TAIL = 150;
  localparam int unsigned TAIL_CYC  = 8;
  localparam int unsigned SYNC_GAP  = 500;

  // Command codes above CMD_DOWN have no function in the block.
  localparam logic [CmdW-1:0] CMD_SPARE_TOP = 3'd7;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    bit                 drain;
    bit                 calm;
  } button_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // tdata: load_hour[4:0], load_minute[10:5], load_year[17:11],
  //        load_month[21:18], load_day[26:22], zero[31:27]
  logic [31:0] in_tdata   = '0;
  // tuser: command[2:0]
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tdata: hour_out[4:0], minute_out[10:5], year_out[17:11], month_out[21:18],
  //        day_out[26:22], edit_position[29:27], done_res[30], zero[31]
  logic [31:0] out_tdata;

  button_item_t button_q[$];
  edit_state_t  edit_expect_q[$];
  edit_state_t  edit_shadow;
  button_item_t cur_button;

  int unsigned n_queued   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_err      = 0;
  int unsigned n_loads    = 0;
  int unsigned n_finished = 0;
  int unsigned n_spare    = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          drain_next = 1'b0;
  bit          calm_mode  = 1'b0;
  bit          calm       = 1'b0;

  clock_field_set_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [StepW-1:0] clamp_field(input logic [StepW-1:0] v,
                                                   input logic [StepW-1:0] lo,
                                                   input logic [StepW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Up lowers the value and down raises it; both wrap inside lo..hi.
  function automatic logic [StepW-1:0] roll_field(input logic [StepW-1:0] v,
                                                  input logic [StepW-1:0] lo,
                                                  input logic [StepW-1:0] hi,
                                                  input bit               lower);
    if (lower) return (v <= lo || v > hi) ? hi : v - StepW'(1);
    return (v >= hi || v < lo) ? lo : v + StepW'(1);
  endfunction

  function automatic edit_state_t apply_button(input edit_state_t s, input button_item_t b);
    edit_state_t n;
    bit          lower;
    n = s;
    lower = (b.cmd == CMD_UP);
    if (b.cmd == CMD_LOAD) begin
      n.fields.hour   = HourW'(clamp_field(StepW'(b.hour), StepW'(0), StepW'(HOUR_MAX)));
      n.fields.minute = MinuteW'(clamp_field(StepW'(b.minute), StepW'(0),
                                             StepW'(MINUTE_MAX)));
      n.fields.year   = YearW'(clamp_field(StepW'(b.year), StepW'(0), StepW'(YEAR_MAX)));
      n.fields.month  = MonthW'(clamp_field(StepW'(b.month), StepW'(MONTH_MIN),
                                            StepW'(MONTH_MAX)));
      n.fields.day    = DayW'(clamp_field(StepW'(b.day), StepW'(DAY_MIN), StepW'(DAY_MAX)));
      n.pos  = POS_HOUR;
      n.done = 1'b0;
    end else if (!s.done) begin
      case (b.cmd)
        CMD_NEXT: begin
          if (s.pos >= POS_DAY) begin
            n.pos  = POS_DAY;
            n.done = 1'b1;
          end else begin
            n.pos = s.pos + PosW'(1);
          end
        end
        CMD_PREV: begin
          if (s.pos != POS_HOUR) n.pos = s.pos - PosW'(1);
        end
        CMD_UP, CMD_DOWN: begin
          case (s.pos)
            POS_HOUR: n.fields.hour = HourW'(roll_field(StepW'(s.fields.hour), StepW'(0),
                                                        StepW'(HOUR_MAX), lower));
            POS_MINUTE: n.fields.minute = MinuteW'(roll_field(StepW'(s.fields.minute),
                                                              StepW'(0),
                                                              StepW'(MINUTE_MAX), lower));
            POS_YEAR: n.fields.year = YearW'(roll_field(StepW'(s.fields.year), StepW'(0),
                                                        StepW'(YEAR_MAX), lower));
            POS_MONTH: n.fields.month = MonthW'(roll_field(StepW'(s.fields.month),
                                                           StepW'(MONTH_MIN),
                                                           StepW'(MONTH_MAX), lower));
            POS_DAY: n.fields.day = DayW'(roll_field(StepW'(s.fields.day), StepW'(DAY_MIN),
                                                     StepW'(DAY_MAX), lower));
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    return n;
  endfunction

  // ------------------------------------------------------------ item creation
  // Mostly legal values, with the range ends and full-width values mixed in.
  function automatic int unsigned pick_value(input int unsigned w, input int unsigned lo,
                                             input int unsigned hi);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2, 3: return $urandom_range(0, (1 << w) - 1);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [CmdW-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return CMD_LOAD;
    if (r < 24) return CMD_NEXT;
    if (r < 38) return CMD_PREV;
    if (r < 66) return CMD_UP;
    if (r < 94) return CMD_DOWN;
    return CmdW'($urandom_range(CMD_DOWN + 1, CMD_SPARE_TOP));
  endfunction

  task automatic add_item(input logic [CmdW-1:0] cmd, input int unsigned h,
                          input int unsigned m, input int unsigned y,
                          input int unsigned mo, input int unsigned d);
    button_item_t b;
    b.cmd    = cmd;
    b.hour   = HourW'(h);
    b.minute = MinuteW'(m);
    b.year   = YearW'(y);
    b.month  = MonthW'(mo);
    b.day    = DayW'(d);
    b.drain  = drain_next;
    b.calm   = calm_mode;
    drain_next = 1'b0;
    button_q.push_back(b);
    n_queued++;
  endtask

  // The load fields ride along with every command; only load looks at them.
  task automatic add_button(input logic [CmdW-1:0] cmd);
    add_item(cmd, pick_value(HourW, 0, HOUR_MAX), pick_value(MinuteW, 0, MINUTE_MAX),
             pick_value(YearW, 0, YEAR_MAX), pick_value(MonthW, MONTH_MIN, MONTH_MAX),
             pick_value(DayW, DAY_MIN, DAY_MAX));
  endtask

  // --------------------------------------------------------------- stimulus
  initial begin
    int unsigned      last_drain;
    int unsigned      runlen;
    logic [CmdW-1:0]  dir;

    edit_shadow.fields.hour   = '0;
    edit_shadow.fields.minute = '0;
    edit_shadow.fields.year   = '0;
    edit_shadow.fields.month  = MONTH_MIN;
    edit_shadow.fields.day    = DAY_MIN;
    edit_shadow.pos           = POS_HOUR;
    edit_shadow.done          = 1'b0;

    // Buttons before any load act on the reset values.
    add_button(CMD_UP);
    add_button(CMD_DOWN);
    add_button(CMD_NEXT);
    add_button(CMD_UP);
    add_button(CMD_PREV);
    add_button(CMD_PREV);
    add_button(CMD_SPARE_TOP);
    // All-ones load clamps every field to its top value.
    add_item(CMD_LOAD, 31, 63, 127, 15, 31);
    add_button(CMD_DOWN);
    add_button(CMD_NEXT);
    add_button(CMD_DOWN);
    add_button(CMD_NEXT);
    add_button(CMD_DOWN);
    add_button(CMD_UP);
    add_button(CMD_NEXT);
    add_button(CMD_DOWN);
    add_button(CMD_UP);
    add_button(CMD_NEXT);
    add_button(CMD_DOWN);
    add_button(CMD_UP);
    // Stepping past day finishes; the following buttons must be ignored.
    add_button(CMD_NEXT);
    add_button(CMD_UP);
    add_button(CMD_NEXT);
    // All-zero load pulls month and day up to one.
    add_item(CMD_LOAD, 0, 0, 0, 0, 0);

    drain_next = 1'b1;
    last_drain = n_queued;
    while (n_queued < ITEMS) begin
      calm_mode = (n_queued + CALM_TAIL >= ITEMS) || ($urandom_range(0, 7) == 0);
      if (n_queued - last_drain >= SYNC_GAP) begin
        drain_next = 1'b1;
        last_drain = n_queued;
      end
      add_button(CMD_LOAD);
      if ($urandom_range(0, 9) < 6) begin
        // Orderly walk through all five fields, sometimes with long runs that wrap.
        for (int p = 0; p < 5; p++) begin
          runlen = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 110) : $urandom_range(0, 6);
          dir = $urandom_range(0, 1) ? CMD_UP : CMD_DOWN;
          repeat (runlen) begin
            if ($urandom_range(0, 9) == 0) add_button(dir == CMD_UP ? CMD_DOWN : CMD_UP);
            else add_button(dir);
          end
          if ($urandom_range(0, 7) == 0) begin
            add_button(CMD_PREV);
            add_button(CMD_NEXT);
          end
          add_button(CMD_NEXT);
        end
        repeat ($urandom_range(0, 3)) add_button(CmdW'($urandom_range(CMD_NEXT, CMD_SPARE_TOP)));
      end else begin
        repeat ($urandom_range(3, 40)) add_button(pick_command());
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (!(button_q.size() == 0 && !in_tvalid && n_checked == n_sent)) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);

    $display("Ran %0d button items over %0d loads; %0d edits reached done, %0d unused codes.",
             n_sent, n_loads, n_finished, n_spare);
    if (n_err == 0) begin
      $display("clock_field_set_sequencer: match");
    end else begin
      $display("clock_field_set_sequencer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d of %0d results checked.", n_checked, n_sent);
    $display("clock_field_set_sequencer: mismatch");
    $finish;
  end

  // ----------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    edit_state_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        nxt = apply_button(edit_shadow, cur_button);
        if (cur_button.cmd == CMD_LOAD) n_loads++;
        if (cur_button.cmd > CMD_DOWN) n_spare++;
        if (nxt.done && !edit_shadow.done) n_finished++;
        edit_shadow = nxt;
        edit_expect_q.push_back(nxt);
        n_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (button_q.size() == 0 || (button_q[0].drain && n_sent != n_checked)) begin
          in_tvalid <= 1'b0;
        end else if (!button_q[0].calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          cur_button = button_q.pop_front();
          calm      <= cur_button.calm;
          in_tvalid <= 1'b1;
          in_tuser  <= cur_button.cmd;
          in_tdata  <= {5'b0, cur_button.day, cur_button.month, cur_button.year,
                        cur_button.minute, cur_button.hour};
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      n_err++;
      $display("%0t: result %0d %s expected %0d, got %0d", $time, n_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    edit_state_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (edit_expect_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want = edit_expect_q.pop_front();
          check_field("hour", want.fields.hour, out_tdata[4:0]);
          check_field("minute", want.fields.minute, out_tdata[10:5]);
          check_field("year", want.fields.year, out_tdata[17:11]);
          check_field("month", want.fields.month, out_tdata[21:18]);
          check_field("day", want.fields.day, out_tdata[26:22]);
          check_field("position", want.pos, out_tdata[29:27]);
          check_field("done", want.done, out_tdata[30]);
          check_field("padding", 0, out_tdata[31]);
        end
        n_checked <= n_checked + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule

[clock_field_set_sequencer.f]
rtl/core/cfss_pkg.sv
rtl/core/cfss_next.sv
rtl/core/clock_field_set_sequencer.sv
dv/tb_clock_field_set_sequencer.sv
